@@ rtl/core/token_address_assignment_master_macros.svh @@
// Assertion macros for the token address-assignment checker
`ifndef TOKEN_ADDRESS_ASSIGNMENT_MASTER_MACROS_SVH
`define TOKEN_ADDRESS_ASSIGNMENT_MASTER_MACROS_SVH

// Same-cycle implication, quiet during reset
`define TAA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, quiet during reset
`define TAA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/taa_pkg.sv @@
// Shared types and constants of the token address-assignment master
package taa_pkg;

    localparam int unsigned RACK_CAPACITY = 32;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] TOKEN_MARKER   = 8'hAA;
    localparam logic [7:0] CONFIRM_MARKER = 8'hCC;
    localparam logic [15:0] BACKOFF_BASE  = 16'd5;

    // Input commands
    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_TICK    = 2'd1,
        CMD_RX      = 2'd2,
        CMD_TX_DONE = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_WINDOW_TICKS  = 3'd0,
        CFG_RETRY_LIMIT   = 3'd1,
        CFG_UNASSIGNED    = 3'd2,
        CFG_TOKEN_ID      = 3'd3,
        CFG_RESPONSE_ID   = 3'd4,
        CFG_CONFIRM_ID    = 3'd5
    } cfg_idx_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_TOKEN    = 3'd0,
        KIND_CONFIRM  = 3'd1,
        KIND_RECORD   = 3'd2,
        KIND_FINISHED = 3'd3,
        KIND_REJECTED = 3'd4
    } kind_t;

    // One-hot walk phases
    typedef enum logic [4:0] {
        PH_IDLE          = 5'b00001,
        PH_AWAIT_TX      = 5'b00010,
        PH_WINDOW        = 5'b00100,
        PH_BACKOFF       = 5'b01000,
        PH_AWAIT_CONFIRM = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t        kind;
        logic [28:0]  frame_id;
        logic [63:0]  payload;
        logic [7:0]   addr;
        logic [55:0]  hw_id;
        logic [7:0]   count;
        logic         last;
    } res_t;

endpackage

@@ rtl/core/taa_res_fifo.sv @@
// Result queue taking up to two results per cycle and giving one per cycle while pop_ready is high
module taa_res_fifo
    import taa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_n,
    input  res_t       push_d0,
    input  res_t       push_d1,
    output logic       room2,
    output logic       pop_valid,
    input  logic       pop_ready,
    output res_t       pop_d
);

    res_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  pop;

    // Report room for a full pair of results
    assign room2     = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop_valid = (cnt_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_d     = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);
        wr_ptr_next  = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next  = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next     = cnt_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store results in arrival order
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_d0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push_d1;
        end
    end

endmodule

@@ rtl/core/token_address_assignment_master.sv @@
// Token address-assignment master: walk state, event decode and result queue
// Output: a transaction's results are offered in the cycle after it is accepted
//   when the result queue is empty; a second result follows once the first is taken.
// Throughput: one input transaction per cycle; in_ready drops while the
//   four-entry result queue holds more than two results.
// Reset: asynchronous; clears the walk state and loads register defaults.
module token_address_assignment_master
    import taa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [28:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  rack_target,
    input  logic        rx_extended,
    input  logic [28:0] rx_frame_id,
    input  logic [3:0]  rx_length,
    input  logic [63:0] rx_payload,
    input  logic        tx_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_kind,
    output logic [28:0] frame_id,
    output logic [63:0] frame_payload,
    output logic [7:0]  assigned_address,
    output logic [55:0] assigned_hw_id,
    output logic [7:0]  rack_tally,
    output logic        last
);

    // Configuration registers
    logic [15:0] window_ticks_reg;
    logic [3:0]  retry_limit_reg;
    logic [7:0]  unassigned_reg;
    logic [28:0] token_id_reg;
    logic [28:0] response_id_reg;
    logic [28:0] confirm_id_reg;

    // Walk state
    phase_t      phase_reg,  phase_next;
    logic [7:0]  cand_reg,   cand_next;
    logic [3:0]  retry_reg,  retry_next;
    logic [7:0]  total_reg,  total_next;
    logic [7:0]  wanted_reg, wanted_next;
    logic [1:0]  resp_cnt_reg, resp_cnt_next;
    logic [55:0] resp_id_reg,  resp_id_next;
    logic [15:0] wait_reg,   wait_next;
    logic [7:0]  tick_reg,   tick_next;

    logic        accept;
    logic [1:0]  push_n;
    res_t        res0;
    res_t        res1;
    res_t        head;

    logic        do_close;
    logic        do_retry;
    logic        do_next;
    logic        do_token;
    logic        rx_hit;
    logic [3:0]  rx_len;
    logic [2:0]  id_bytes;
    logic [3:0]  lim;

    assign accept = in_valid && in_ready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_ticks_reg <= 16'd100;
            retry_limit_reg  <= 4'd3;
            unassigned_reg   <= 8'd0;
            token_id_reg     <= 29'd256;
            response_id_reg  <= 29'd257;
            confirm_id_reg   <= 29'd258;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_TICKS: window_ticks_reg <= cfg_data[15:0];
                CFG_RETRY_LIMIT:  retry_limit_reg  <= cfg_data[3:0];
                CFG_UNASSIGNED:   unassigned_reg   <= cfg_data[7:0];
                CFG_TOKEN_ID:     token_id_reg     <= cfg_data;
                CFG_RESPONSE_ID:  response_id_reg  <= cfg_data;
                CFG_CONFIRM_ID:   confirm_id_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Decode the transaction and resolve the walk chain
    always_comb
    begin
        phase_next    = phase_reg;
        cand_next     = cand_reg;
        retry_next    = retry_reg;
        total_next    = total_reg;
        wanted_next   = wanted_reg;
        resp_cnt_next = resp_cnt_reg;
        resp_id_next  = resp_id_reg;
        wait_next     = wait_reg;
        tick_next     = tick_reg;
        push_n        = 2'd0;
        res0          = '0;
        res1          = '0;
        do_close      = 1'b0;
        do_retry      = 1'b0;
        do_next       = 1'b0;
        do_token      = 1'b0;
        rx_len        = (rx_length > 4'd8) ? 4'd8 : rx_length;
        id_bytes      = 3'(rx_len - 4'd1);
        rx_hit        = (phase_reg == PH_WINDOW) && rx_extended &&
                        (rx_frame_id == response_id_reg) && (rx_length != 4'd0) &&
                        (rx_payload[7:0] == unassigned_reg);
        lim           = (retry_limit_reg == 4'd0) ? 4'd1 : retry_limit_reg;

        if (accept)
        begin
            unique case (cmd)
                CMD_START:
                begin
                    if ((rack_target == 8'd0) ||
                        (rack_target > 8'(RACK_CAPACITY)))
                    begin
                        res0.kind = KIND_REJECTED;
                        push_n    = 2'd1;
                    end
                    else
                    begin
                        wanted_next   = rack_target;
                        total_next    = 8'd0;
                        cand_next     = 8'd1;
                        retry_next    = 4'd0;
                        resp_cnt_next = 2'd0;
                        resp_id_next  = '0;
                        wait_next     = 16'd0;
                        do_token      = 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    tick_next = tick_reg + 8'd1;
                    if (phase_reg == PH_WINDOW)
                    begin
                        wait_next = wait_reg + 16'd1;
                        do_close  = (wait_next >= window_ticks_reg);
                    end
                    else if (phase_reg == PH_BACKOFF)
                    begin
                        wait_next = (wait_reg != 16'd0) ? wait_reg - 16'd1 : 16'd0;
                        do_retry  = (wait_next == 16'd0);
                    end
                end
                CMD_RX:
                begin
                    if (rx_hit)
                    begin
                        // Capture id bytes of the first responder only
                        if (resp_cnt_reg == 2'd0)
                        begin
                            for (int b = 0; b < 7; b++)
                            begin
                                resp_id_next[8*b +: 8] = (3'(b) < id_bytes) ?
                                    rx_payload[8*b + 8 +: 8] : 8'd0;
                            end
                        end
                        if (resp_cnt_reg != 2'd2)
                        begin
                            resp_cnt_next = resp_cnt_reg + 2'd1;
                        end
                        if (resp_cnt_next == 2'd2)
                        begin
                            phase_next = PH_BACKOFF;
                            wait_next  = BACKOFF_BASE + {11'd0, retry_reg, 1'b0};
                        end
                    end
                end
                CMD_TX_DONE:
                begin
                    if (phase_reg == PH_AWAIT_TX)
                    begin
                        if (tx_ok)
                        begin
                            phase_next    = PH_WINDOW;
                            resp_cnt_next = 2'd0;
                            resp_id_next  = '0;
                            wait_next     = 16'd0;
                        end
                        else
                        begin
                            do_retry = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_AWAIT_CONFIRM)
                    begin
                        do_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // Close window: confirm a lone responder, else move on
        if (do_close)
        begin
            if (resp_cnt_reg == 2'd1)
            begin
                res0.kind     = KIND_CONFIRM;
                res0.frame_id = confirm_id_reg;
                res0.payload  = {48'd0, cand_reg, CONFIRM_MARKER};
                res1.kind     = KIND_RECORD;
                res1.addr     = cand_reg;
                res1.hw_id    = resp_id_reg;
                push_n        = 2'd2;
                total_next    = total_reg + 8'd1;
                phase_next    = PH_AWAIT_CONFIRM;
            end
            else
            begin
                do_next = 1'b1;
            end
        end

        // Use up one retry, then step on at the limit or send the token again
        if (do_retry)
        begin
            retry_next = retry_reg + 4'd1;
            if (retry_next >= lim)
            begin
                do_next = 1'b1;
            end
            else
            begin
                do_token = 1'b1;
            end
        end

        // Step to the next candidate or finish
        if (do_next)
        begin
            cand_next  = cand_reg + 8'd1;
            retry_next = 4'd0;
            if ((cand_next == 8'd0) || (cand_next > 8'(RACK_CAPACITY)) ||
                (total_next >= wanted_next))
            begin
                res0.kind  = KIND_FINISHED;
                res0.count = total_next;
                push_n     = 2'd1;
                phase_next = PH_IDLE;
            end
            else
            begin
                do_token = 1'b1;
            end
        end

        // Send a token for the current candidate
        if (do_token)
        begin
            res0.kind     = KIND_TOKEN;
            res0.frame_id = token_id_reg;
            res0.payload  = {40'd0, tick_next, cand_next, TOKEN_MARKER};
            push_n        = 2'd1;
            phase_next    = PH_AWAIT_TX;
        end

        // Mark the final result of this transaction
        if (push_n == 2'd1)
        begin
            res0.last = 1'b1;
        end
        else if (push_n == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    // Hold walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            cand_reg     <= '0;
            retry_reg    <= '0;
            total_reg    <= '0;
            wanted_reg   <= '0;
            resp_cnt_reg <= '0;
            resp_id_reg  <= '0;
            wait_reg     <= '0;
            tick_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cand_reg     <= cand_next;
            retry_reg    <= retry_next;
            total_reg    <= total_next;
            wanted_reg   <= wanted_next;
            resp_cnt_reg <= resp_cnt_next;
            resp_id_reg  <= resp_id_next;
            wait_reg     <= wait_next;
            tick_reg     <= tick_next;
        end
    end

    // Queue results toward the output channel
    taa_res_fifo u_res_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push_d0   (res0),
        .push_d1   (res1),
        .room2     (in_ready),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_d     (head)
    );

    assign out_kind         = head.kind;
    assign frame_id         = head.frame_id;
    assign frame_payload    = head.payload;
    assign assigned_address = head.addr;
    assign assigned_hw_id   = head.hw_id;
    assign rack_tally       = head.count;
    assign last             = head.last;

endmodule

@@ rtl/core/taa_checker.sv @@
// Port-level checker for the token address-assignment master, with its bind
`include "token_address_assignment_master_macros.svh"

module taa_checker
    import taa_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [28:0] frame_id,
    input logic [7:0] rack_tally,
    input logic       last
);

    logic out_take;
    logic out_stall;
    logic show_confirm;
    logic show_record;
    logic show_finished;

    // Decode what the output channel shows
    assign out_take      = out_valid && out_ready;
    assign out_stall     = out_valid && !out_ready;
    assign show_confirm  = out_valid && (out_kind == KIND_CONFIRM);
    assign show_record   = out_valid && (out_kind == KIND_RECORD);
    assign show_finished = out_valid && (out_kind == KIND_FINISHED);

    // Hold a stalled result
    `TAA_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_kind))

    // A confirm transaction is always followed by its assignment record
    `TAA_ASSERT_NXT(a_confirm_then_record, clk, rst_n, out_take && show_confirm, show_record)

    // A record closes its transaction group and carries no frame id
    `TAA_ASSERT_IMP(a_record_last, clk, rst_n, show_record, last && (frame_id == 29'd0))

    // The finished tally never exceeds the rack capacity
    `TAA_ASSERT_IMP(a_count_range, clk, rst_n, show_finished, rack_tally <= 8'(RACK_CAPACITY))

endmodule

bind token_address_assignment_master taa_checker u_taa_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .frame_id       (frame_id),
    .rack_tally     (rack_tally),
    .last           (last)
);
